/* rtl/etok_pkg.sv */
// ----------------------------------------------------------------------------
// etok_pkg: shared types and constants of the expression tokenizer
// Token kinds, token and bundle records, and the sizes of the bundle queue.
// ----------------------------------------------------------------------------
package etok_pkg;

    localparam int FIELD_BITS  = 16;
    localparam int MAX_TOKENS  = 3;
    localparam int COUNT_BITS  = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_LPAREN = 4'd0,
        KIND_RPAREN = 4'd1,
        KIND_STAR   = 4'd2,
        KIND_SLASH  = 4'd3,
        KIND_PLUS   = 4'd4,
        KIND_MINUS  = 4'd5,
        KIND_IDENT  = 4'd6,
        KIND_NUMBER = 4'd7,
        KIND_END    = 4'd8,
        KIND_ERROR  = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
    } token_t;

    // All tokens caused by one source byte, in output order.
    typedef struct packed {
        logic [COUNT_BITS-1:0]     count;
        token_t [MAX_TOKENS-1:0]   tok;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } slot_t;

endpackage

/* rtl/expression_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// expression_tokenizer_unit: streaming lexer for arithmetic expressions
// Source bytes in, tokens (kind, start, length) out over valid/ready.
// ----------------------------------------------------------------------------
// The block takes one source byte per beat, end_of_source marking the last
// byte of a text, and gives one token per beat. A byte is taken in the cycle
// it is offered whenever the bundle queue has room, so text streams in at one
// byte per cycle. Each byte causes zero to three tokens: the close of a
// pending identifier or number, an operator or error token, and on the final
// byte the close of a token that the byte extends or opens, then the end token.
// Tokens leave at one per cycle while out_ready holds, through a registered
// output, so the sustained rate is set by the token drain, which gives out
// the tokens of each bundle in turn, and a four-bundle queue absorbs bursts of
// busy bytes. A token is written into the bundle queue and then loaded into
// the output register before it shows on the outputs.
// last_of_run flags the final token caused by a byte. After an
// unknown byte the block drops bytes until the final one. Positions count
// from zero per text, stop at the top of their POSITION_BITS range, and are
// reported clipped to 16 bits.
// ----------------------------------------------------------------------------
module expression_tokenizer_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,
    input  logic        end_of_source,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    etok_pkg::slot_t push;
    etok_pkg::slot_t head;
    logic            pop;
    logic            full;
    logic            accept;

    // Take a byte whenever a whole bundle still fits in the queue.
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Classify the byte and advance the scan state.
    etok_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .character     (character),
        .end_of_source (end_of_source),
        .accept        (accept),
        .push          (push)
    );

    // Decouple the byte side from the token side.
    etok_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (full)
    );

    // Drain bundles one token per beat.
    etok_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

endmodule

/* rtl/etok_front.sv */
// ----------------------------------------------------------------------------
// etok_front: byte classifier and scan state
// Classifies each accepted byte, tracks the pending lexeme and builds the
// bundle of tokens that the byte causes.
// ----------------------------------------------------------------------------
module etok_front #(
    parameter int POSITION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          character,
    input  logic                end_of_source,
    input  logic                accept,
    output etok_pkg::slot_t     push
);

    localparam int WIDE = (POSITION_BITS > etok_pkg::FIELD_BITS) ?
                          POSITION_BITS : etok_pkg::FIELD_BITS;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_IDENT   = 5'b00010,
        MODE_INT     = 5'b00100,
        MODE_FRAC    = 5'b01000,
        MODE_DISCARD = 5'b10000
    } mode_t;

    mode_t                    mode_reg, mode_next, mode_mid;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] pend_reg, pend_next, pend_mid;
    logic [POSITION_BITS-1:0] np;

    logic           is_digit, is_letter, is_space, is_point, is_op;
    etok_pkg::kind_t op_kind;
    logic           close_a, emit_b, close_c;
    etok_pkg::token_t tok_a, tok_b, tok_c, tok_d;
    etok_pkg::bundle_t bundle;
    logic [etok_pkg::COUNT_BITS-1:0] n;

    function automatic logic [etok_pkg::FIELD_BITS-1:0] clamp_field(
        input logic [POSITION_BITS-1:0] v
    );
        logic [WIDE-1:0] w;
        begin
            w = WIDE'(v);
            return ((w >> etok_pkg::FIELD_BITS) != '0) ? '1 : w[etok_pkg::FIELD_BITS-1:0];
        end
    endfunction

    function automatic logic [POSITION_BITS-1:0] span(
        input logic [POSITION_BITS-1:0] stop,
        input logic [POSITION_BITS-1:0] from
    );
        begin
            return (stop >= from) ? stop - from : '0;
        end
    endfunction

    always_comb
    begin
        is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
        is_letter = ((character >= CH_LOWER_A) && (character <= CH_LOWER_Z)) ||
                    ((character >= CH_UPPER_A) && (character <= CH_UPPER_Z));
        is_space  = (character == CH_LF) || (character == CH_CR) ||
                    (character == CH_TAB) || (character == CH_SPACE);
        is_point  = (character == CH_POINT);
        is_op     = 1'b1;
        op_kind   = etok_pkg::KIND_ERROR;
        unique case (character)
            CH_LPAREN: op_kind = etok_pkg::KIND_LPAREN;
            CH_RPAREN: op_kind = etok_pkg::KIND_RPAREN;
            CH_STAR:   op_kind = etok_pkg::KIND_STAR;
            CH_SLASH:  op_kind = etok_pkg::KIND_SLASH;
            CH_PLUS:   op_kind = etok_pkg::KIND_PLUS;
            CH_MINUS:  op_kind = etok_pkg::KIND_MINUS;
            default:   is_op = 1'b0;
        endcase
    end

    assign np = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    // Resolve the pending lexeme, then lex the byte on its own if not absorbed.
    always_comb
    begin
        logic absorbed;
        absorbed = 1'b0;
        close_a  = 1'b0;
        emit_b   = 1'b0;
        mode_mid = MODE_IDLE;
        pend_mid = pend_reg;
        tok_b.kind   = op_kind;
        tok_b.start  = clamp_field(pos_reg);
        tok_b.length = etok_pkg::FIELD_BITS'(1);

        unique case (mode_reg)
            MODE_IDENT:
            begin
                absorbed = is_letter || is_digit;
                close_a  = !absorbed;
                mode_mid = absorbed ? MODE_IDENT : MODE_IDLE;
            end
            MODE_INT:
            begin
                absorbed = is_digit || is_point;
                close_a  = !absorbed;
                mode_mid = is_point ? MODE_FRAC : (absorbed ? MODE_INT : MODE_IDLE);
            end
            MODE_FRAC:
            begin
                absorbed = is_digit;
                close_a  = !absorbed;
                mode_mid = absorbed ? MODE_FRAC : MODE_IDLE;
            end
            MODE_DISCARD:
            begin
                absorbed = 1'b1;
                mode_mid = MODE_DISCARD;
            end
            default:
            begin
                mode_mid = MODE_IDLE;
            end
        endcase

        if (!absorbed)
        begin
            if (is_op)
            begin
                emit_b = 1'b1;
            end
            else if (is_space)
            begin
                mode_mid = MODE_IDLE;
            end
            else if (is_letter)
            begin
                mode_mid = MODE_IDENT;
                pend_mid = pos_reg;
            end
            else if (is_digit)
            begin
                mode_mid = MODE_INT;
                pend_mid = pos_reg;
            end
            else
            begin
                emit_b     = 1'b1;
                tok_b.kind = etok_pkg::KIND_ERROR;
                mode_mid   = MODE_DISCARD;
            end
        end
    end

    always_comb
    begin
        tok_a.kind   = (mode_reg == MODE_IDENT) ? etok_pkg::KIND_IDENT : etok_pkg::KIND_NUMBER;
        tok_a.start  = clamp_field(pend_reg);
        tok_a.length = clamp_field(span(pos_reg, pend_reg));

        close_c      = end_of_source &&
                       ((mode_mid == MODE_IDENT) || (mode_mid == MODE_INT) ||
                        (mode_mid == MODE_FRAC));
        tok_c.kind   = (mode_mid == MODE_IDENT) ? etok_pkg::KIND_IDENT : etok_pkg::KIND_NUMBER;
        tok_c.start  = clamp_field(pend_mid);
        tok_c.length = clamp_field(span(np, pend_mid));

        tok_d.kind   = etok_pkg::KIND_END;
        tok_d.start  = clamp_field(np);
        tok_d.length = '0;
    end

    // Pack the tokens of this byte into consecutive bundle slots.
    always_comb
    begin
        bundle = '0;
        n      = '0;
        if (close_a)
        begin
            bundle.tok[n] = tok_a;
            n = n + 1'b1;
        end
        if (emit_b)
        begin
            bundle.tok[n] = tok_b;
            n = n + 1'b1;
        end
        if (close_c)
        begin
            bundle.tok[n] = tok_c;
            n = n + 1'b1;
        end
        if (end_of_source)
        begin
            bundle.tok[n] = tok_d;
            n = n + 1'b1;
        end
        bundle.count = n;
    end

    assign push.valid  = accept && (n != '0);
    assign push.bundle = bundle;

    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        pend_next = pend_reg;
        if (accept)
        begin
            if (end_of_source)
            begin
                mode_next = MODE_IDLE;
                pos_next  = '0;
                pend_next = '0;
            end
            else
            begin
                mode_next = mode_mid;
                pos_next  = np;
                pend_next = pend_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

endmodule

/* rtl/etok_queue.sv */
// ----------------------------------------------------------------------------
// etok_queue: bundle queue between classifier and token drain
// Holds up to four bundles so that input and output can stall independently.
// ----------------------------------------------------------------------------
module etok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  etok_pkg::slot_t   push,
    input  logic              pop,
    output etok_pkg::slot_t   head,
    output logic              full
);

    etok_pkg::bundle_t                entry_reg [etok_pkg::QUEUE_DEPTH];
    logic [etok_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [etok_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [etok_pkg::QCNT_BITS-1:0]   cnt_reg, cnt_next;

    assign full        = (cnt_reg == etok_pkg::QCNT_BITS'(etok_pkg::QUEUE_DEPTH));
    assign head.valid  = (cnt_reg != '0);
    assign head.bundle = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        case ({push.valid, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.bundle;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !full)
        else $error("etok_queue: bundle written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("etok_queue: bundle removed while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (push.bundle.count != '0))
        else $error("etok_queue: empty bundle written");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= etok_pkg::QCNT_BITS'(etok_pkg::QUEUE_DEPTH))
        else $error("etok_queue: fill count beyond depth");
`endif

endmodule

/* rtl/etok_back.sv */
// ----------------------------------------------------------------------------
// etok_back: token drain
// Walks the head bundle one token per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module etok_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  etok_pkg::slot_t                     head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [3:0]                          token_kind,
    output logic [etok_pkg::FIELD_BITS-1:0]     token_start,
    output logic [etok_pkg::FIELD_BITS-1:0]     token_length,
    output logic                                last_of_run
);

    logic [etok_pkg::COUNT_BITS-1:0] idx_reg, idx_next;
    logic                            valid_reg, valid_next;
    etok_pkg::token_t                tok_reg;
    logic                            last_reg;
    logic                            load, at_last;

    assign load    = head.valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.bundle.count - 1'b1);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the beat is taken.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= head.bundle.tok[idx_reg];
            last_reg <= at_last;
        end
    end

    assign out_valid    = valid_reg;
    assign token_kind   = tok_reg.kind;
    assign token_start  = tok_reg.start;
    assign token_length = tok_reg.length;
    assign last_of_run  = last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (idx_reg < head.bundle.count))
        else $error("etok_back: token index past bundle count");
    assert property (@(posedge clk) disable iff (!rst_n) !head.valid |-> (idx_reg == '0))
        else $error("etok_back: token index left over with no bundle");
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> (idx_reg == '0))
        else $error("etok_back: token index not rewound after bundle");
`endif

endmodule
